/* src/tlgpw_pkg.sv */
// ---------------------------------------------------------------------------
// tlgpw_pkg : shared types and constants of the two-level page walker
// Request codes, walk phases, queue sizes and the structs passed between
// the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
package tlgpw_pkg;

    localparam int NUM_CONTEXTS = 16;
    localparam int CTX_W        = 4;
    localparam int CTX_IDX_W    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    // address slicing of the two table levels
    localparam int DIR_IDX_LSB = 23;
    localparam int DIR_IDX_W   = 20;
    localparam int PT_IDX_LSB  = 12;
    localparam int PT_IDX_W    = 11;
    localparam int PAGE_OFS_W  = 12;
    localparam int ENTRY_SHIFT = 3;

    localparam logic [63:0] PT_BASE_MASK = ~64'hFF;
    localparam logic [63:0] PAGE_MASK_4K = 64'hFFF;
    localparam logic [63:0] MASK_ALL     = ~64'h0;

    typedef enum logic [1:0] {
        KIND_SET_BASE = 2'd0,
        KIND_XLATE    = 2'd1,
        KIND_RD_DATA  = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_in_kind;

    typedef enum logic {
        OUT_RD_REQ = 1'b0,
        OUT_RESULT = 1'b1
    } t_out_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DIR  = 2'd1,
        PH_PTE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_UNMAPPED = 2'd0,
        OP_DIR_RD   = 2'd1,
        OP_PT_RD    = 2'd2,
        OP_DONE     = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] val;   // directory base or returned table word
        logic [63:0] addr;  // address under translation
    } t_cmd;

    typedef struct packed {
        t_out_kind   out_kind;
        logic [63:0] read_addr;
        logic [63:0] phys_addr;
        logic [63:0] page_mask;
        logic        mapped;
    } t_res;

endpackage

/* src/tlgpw_front.sv */
// ---------------------------------------------------------------------------
// tlgpw_front : request classification and walk tracking
// Holds the per-context directory bases and the walk phase, and turns each
// accepted request into at most one command for the back end.
// ---------------------------------------------------------------------------
module tlgpw_front
    import tlgpw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_kind,
    input  logic [CTX_W-1:0] i_context_id,
    input  logic [63:0]      i_dir_base,
    input  logic [63:0]      i_virt_addr,
    input  logic [63:0]      i_read_data,
    output logic             o_cmd_push,
    output t_cmd             o_cmd
);

    logic [63:0]             r_base [NUM_CONTEXTS];
    logic [NUM_CONTEXTS-1:0] r_base_vld;
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [63:0]             r_held_addr;

    logic                    ctx_ok;
    logic [CTX_IDX_W-1:0]    ctx_idx;
    logic [63:0]             base_rd;
    t_in_kind                kind;

    assign kind    = t_in_kind'(i_kind);
    assign ctx_ok  = (32'(i_context_id) < NUM_CONTEXTS);
    assign ctx_idx = CTX_IDX_W'(i_context_id);
    // unwritten entries read as a disabled (zero) base
    assign base_rd = (ctx_ok && r_base_vld[ctx_idx]) ? r_base[ctx_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (i_accept && kind == KIND_SET_BASE && ctx_ok) begin
            r_base[ctx_idx] <= i_dir_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_vld <= '0;
            r_phase    <= PH_IDLE;
        end else begin
            if (i_accept && kind == KIND_SET_BASE && ctx_ok) begin
                r_base_vld[ctx_idx] <= 1'b1;
            end
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && kind == KIND_XLATE && r_phase == PH_IDLE) begin
            r_held_addr <= i_virt_addr;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (kind == KIND_XLATE && base_rd != '0) begin
                        n_phase = PH_DIR;
                    end
                end
                PH_DIR: begin
                    if (kind == KIND_RD_DATA) begin
                        n_phase = PH_PTE;
                    end
                end
                PH_PTE: begin
                    if (kind == KIND_RD_DATA) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // command issue
    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd.op   = OP_UNMAPPED;
        o_cmd.val  = i_read_data;
        o_cmd.addr = r_held_addr;
        if (i_accept) begin
            unique case (kind) inside
                KIND_XLATE: begin
                    if (r_phase == PH_IDLE) begin
                        o_cmd_push = 1'b1;
                        o_cmd.val  = base_rd;
                        o_cmd.addr = i_virt_addr;
                        o_cmd.op   = (base_rd == '0) ? OP_UNMAPPED : OP_DIR_RD;
                    end
                end
                KIND_RD_DATA: begin
                    if (r_phase == PH_DIR) begin
                        o_cmd_push = 1'b1;
                        o_cmd.op   = OP_PT_RD;
                    end else if (r_phase == PH_PTE) begin
                        o_cmd_push = 1'b1;
                        o_cmd.op   = OP_DONE;
                    end
                end
                KIND_SET_BASE, KIND_UNUSED: begin
                    o_cmd_push = 1'b0;
                end
                default: o_cmd_push = 1'b0;
            endcase
        end
    end

endmodule

/* src/tlgpw_cmdq.sv */
// ---------------------------------------------------------------------------
// tlgpw_cmdq : command queue between front end and back end
// Small circular buffer; lets the front keep taking requests while the
// back end waits on the result side.
// ---------------------------------------------------------------------------
module tlgpw_cmdq
    import tlgpw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_AW:0]   r_count;

    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/tlgpw_back.sv */
// ---------------------------------------------------------------------------
// tlgpw_back : address generation and result formatting
// Computes table read addresses and translation results from commands and
// holds them in a two-entry result buffer.
// ---------------------------------------------------------------------------
module tlgpw_back
    import tlgpw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_res               r_buf [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr_ptr;
    logic [RESQ_AW-1:0] r_rd_ptr;
    logic [RESQ_AW:0]   r_count;

    logic               take;
    logic               do_pop;
    t_res               res;

    assign o_empty   = (r_count == '0);
    assign take      = !i_cmd_empty && (r_count != (RESQ_AW+1)'(RESQ_DEPTH));
    assign do_pop    = i_pop && !o_empty;
    assign o_cmd_pop = take;
    assign o_res     = r_buf[r_rd_ptr];

    always_comb begin
        res.out_kind  = OUT_RD_REQ;
        res.read_addr = '0;
        res.phys_addr = '0;
        res.page_mask = '0;
        res.mapped    = 1'b0;
        unique case (i_cmd.op)
            OP_UNMAPPED: begin
                res.out_kind  = OUT_RESULT;
                res.page_mask = MASK_ALL;
            end
            OP_DIR_RD: begin
                res.read_addr = i_cmd.val + 64'({i_cmd.addr[DIR_IDX_LSB +: DIR_IDX_W],
                                                 ENTRY_SHIFT'(0)});
            end
            OP_PT_RD: begin
                res.read_addr = (i_cmd.val & PT_BASE_MASK)
                              + 64'({i_cmd.addr[PT_IDX_LSB +: PT_IDX_W], ENTRY_SHIFT'(0)});
            end
            OP_DONE: begin
                res.out_kind  = OUT_RESULT;
                res.phys_addr = {i_cmd.val[63:PAGE_OFS_W], i_cmd.addr[PAGE_OFS_W-1:0]};
                res.page_mask = PAGE_MASK_4K;
                res.mapped    = 1'b1;
            end
            default: res.out_kind = OUT_RD_REQ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (take) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (take && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !take) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/two_level_gart_page_walker.sv */
// ---------------------------------------------------------------------------
// two_level_gart_page_walker : per-context two-level page table walker
// Translates device addresses through a directory and a page table held in
// external memory, issuing table reads and returning translation results.
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | carries
//  ---------+---------------------+---------------------------------------------
//  input    | push / full         | kind, context_id, dir_base, virt_addr,
//           |                     | read_data (set base, translate, mem return)
//  result   | empty / pop         | out_kind, read_addr, phys_addr, page_mask,
//           |                     | mapped (table read or translation result)
//
//  One request is taken per cycle while full is low. A request that causes
//  a result passes the command queue write, then the result buffer write,
//  before it can be popped from the result ports, and a full result buffer
//  holds it back; throughput is set by those two queues, not by the walk itself.
//  Reset clears the context table through per-entry valid bits at once: no
//  clearing pass, requests are taken as soon as reset is released.
//  With pop held low the result buffer fills, then the command queue, and
//  full rises; requests that cause no result still need a queue slot free.
//
module two_level_gart_page_walker
    import tlgpw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request side
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_kind,
    input  logic [CTX_W-1:0] i_context_id,
    input  logic [63:0]      i_dir_base,
    input  logic [63:0]      i_virt_addr,
    input  logic [63:0]      i_read_data,
    // result side
    output logic             empty,
    input  logic             pop,
    output logic             o_out_kind,
    output logic [63:0]      o_read_addr,
    output logic [63:0]      o_phys_addr,
    output logic [63:0]      o_page_mask,
    output logic             o_mapped
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic cmd_empty;
    logic cmd_pop;
    t_res res;

    // a request counts only when the command queue has room for its command
    assign accept = push && !full;

    // front end: context table, walk phase, classification
    tlgpw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_context_id (i_context_id),
        .i_dir_base   (i_dir_base),
        .i_virt_addr  (i_virt_addr),
        .i_read_data  (i_read_data),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    // decouples front from back
    tlgpw_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // back end: address arithmetic and result buffer
    tlgpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_out_kind  = res.out_kind;
    assign o_read_addr = res.read_addr;
    assign o_phys_addr = res.phys_addr;
    assign o_page_mask = res.page_mask;
    assign o_mapped    = res.mapped;

endmodule

/* verif/tlgpw_walk_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlgpw_walk_checker : scoreboard for the two-level page walker
// Watches the request and result queues, keeps its own copy of the context
// bases and the walk, and compares each popped result with the oldest one due.
// ---------------------------------------------------------------------------
module tlgpw_walk_checker
    import tlgpw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [1:0]       i_kind,
    input  logic [CTX_W-1:0] i_context_id,
    input  logic [63:0]      i_dir_base,
    input  logic [63:0]      i_virt_addr,
    input  logic [63:0]      i_read_data,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic             i_out_kind,
    input  logic [63:0]      i_read_addr,
    input  logic [63:0]      i_phys_addr,
    input  logic [63:0]      i_page_mask,
    input  logic             i_mapped,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_effective,
    output int               o_walks_done,
    output int               o_unmapped,
    output int               o_compared
);

    logic [63:0] ctx_dir_base [NUM_CONTEXTS];
    t_phase      phase_q;
    logic [63:0] held_va;
    t_res        walk_replies [$];
    t_res        seen;
    int          fails;
    int          effective;
    int          walks_done;
    int          unmapped;
    int          compared;

    function automatic logic [63:0] entry_addr(input logic [63:0] base,
                                               input logic [63:0] idx);
        return base + (idx << ENTRY_SHIFT);
    endfunction

    task automatic predict_request(input t_in_kind         kind,
                                   input logic [CTX_W-1:0] ctx,
                                   input logic [63:0]      base_in,
                                   input logic [63:0]      va,
                                   input logic [63:0]      word);
        t_res        r;
        logic [63:0] base;
        logic        gives;
        r     = '0;
        gives = 1'b0;
        case (kind)
            KIND_SET_BASE: begin
                // takes effect at once, even mid-walk
                if (int'(ctx) < NUM_CONTEXTS) begin
                    ctx_dir_base[ctx] = base_in;
                    effective++;
                end
            end
            KIND_XLATE: begin
                if (phase_q == PH_IDLE) begin
                    base  = (int'(ctx) < NUM_CONTEXTS) ? ctx_dir_base[ctx] : '0;
                    gives = 1'b1;
                    if (base == '0) begin
                        r.out_kind  = OUT_RESULT;
                        r.page_mask = MASK_ALL;
                        unmapped++;
                    end else begin
                        held_va     = va;
                        phase_q     = PH_DIR;
                        r.out_kind  = OUT_RD_REQ;
                        r.read_addr = entry_addr(base, 64'(va[DIR_IDX_LSB +: DIR_IDX_W]));
                    end
                end
            end
            KIND_RD_DATA: begin
                if (phase_q == PH_DIR) begin
                    gives       = 1'b1;
                    phase_q     = PH_PTE;
                    r.out_kind  = OUT_RD_REQ;
                    r.read_addr = entry_addr(word & PT_BASE_MASK,
                                             64'(held_va[PT_IDX_LSB +: PT_IDX_W]));
                end else if (phase_q == PH_PTE) begin
                    gives       = 1'b1;
                    phase_q     = PH_IDLE;
                    r.out_kind  = OUT_RESULT;
                    r.phys_addr = {word[63:PAGE_OFS_W], held_va[PAGE_OFS_W-1:0]};
                    r.page_mask = PAGE_MASK_4K;
                    r.mapped    = 1'b1;
                    walks_done++;
                end
            end
            default: ;
        endcase
        if (gives) begin
            walk_replies.push_back(r);
            effective++;
        end
    endtask

    task automatic check_reply(input t_res got);
        t_res want;
        if (walk_replies.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("%0t: unexpected result kind=%0d ra=%h pa=%h mask=%h map=%0d",
                         $realtime, got.out_kind, got.read_addr, got.phys_addr,
                         got.page_mask, got.mapped);
            return;
        end
        want = walk_replies.pop_front();
        compared++;
        if (got.out_kind !== want.out_kind || got.read_addr !== want.read_addr ||
            got.phys_addr !== want.phys_addr || got.page_mask !== want.page_mask ||
            got.mapped !== want.mapped) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: mismatch, expected kind=%0d ra=%h pa=%h mask=%h map=%0d",
                         $realtime, want.out_kind, want.read_addr, want.phys_addr,
                         want.page_mask, want.mapped);
                $display("%0t:           actual   kind=%0d ra=%h pa=%h mask=%h map=%0d",
                         $realtime, got.out_kind, got.read_addr, got.phys_addr,
                         got.page_mask, got.mapped);
            end
        end
    endtask

    // results are compared before new requests are predicted: nothing can
    // come out in the cycle its request goes in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ctx_dir_base[i]) ctx_dir_base[i] = '0;
            phase_q = PH_IDLE;
            held_va = '0;
            walk_replies.delete();
        end else begin
            if (i_pop && !i_empty) begin
                seen.out_kind  = t_out_kind'(i_out_kind);
                seen.read_addr = i_read_addr;
                seen.phys_addr = i_phys_addr;
                seen.page_mask = i_page_mask;
                seen.mapped    = i_mapped;
                check_reply(seen);
            end
            if (i_push && !i_full)
                predict_request(t_in_kind'(i_kind), i_context_id, i_dir_base,
                                i_virt_addr, i_read_data);
        end
        o_pending    <= walk_replies.size();
        o_fail_count <= fails;
        o_effective  <= effective;
        o_walks_done <= walks_done;
        o_unmapped   <= unmapped;
        o_compared   <= compared;
    end

endmodule

/* verif/tb_two_level_gart_page_walker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_two_level_gart_page_walker : testbench top for the page walker
// Drives base writes, translate requests and memory returns through the
// request queue, pops results with random stalls, and leaves all prediction
// and comparison to the checker instance beside the block.
// ---------------------------------------------------------------------------
module tb_two_level_gart_page_walker;
    import tlgpw_pkg::*;

    // working requests wanted from the random part, and how many of them at
    // the end run without any idling on either side
    localparam int RANDOM_TARGET = 1000;
    localparam int QUIET_TAIL    = 150;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [1:0]       i_kind;
    logic [CTX_W-1:0] i_context_id;
    logic [63:0]      i_dir_base;
    logic [63:0]      i_virt_addr;
    logic [63:0]      i_read_data;
    logic             empty;
    logic             pop;
    logic             o_out_kind;
    logic [63:0]      o_read_addr;
    logic [63:0]      o_phys_addr;
    logic [63:0]      o_page_mask;
    logic             o_mapped;

    int fail_count;
    int pending;
    int effective;
    int walks_done;
    int unmapped;
    int compared;

    // set for the last stretch of the run: no gaps, no stalls
    bit quiet = 1'b0;

    two_level_gart_page_walker uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_context_id (i_context_id),
        .i_dir_base   (i_dir_base),
        .i_virt_addr  (i_virt_addr),
        .i_read_data  (i_read_data),
        .empty        (empty),
        .pop          (pop),
        .o_out_kind   (o_out_kind),
        .o_read_addr  (o_read_addr),
        .o_phys_addr  (o_phys_addr),
        .o_page_mask  (o_page_mask),
        .o_mapped     (o_mapped)
    );

    tlgpw_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_kind       (i_kind),
        .i_context_id (i_context_id),
        .i_dir_base   (i_dir_base),
        .i_virt_addr  (i_virt_addr),
        .i_read_data  (i_read_data),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_kind   (o_out_kind),
        .i_read_addr  (o_read_addr),
        .i_phys_addr  (o_phys_addr),
        .i_page_mask  (o_page_mask),
        .i_mapped     (o_mapped),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_effective  (effective),
        .o_walks_done (walks_done),
        .o_unmapped   (unmapped),
        .o_compared   (compared)
    );

    always #5 i_clk = ~i_clk;

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: pop mostly held high, with random stall bursts
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // holds the request on the port until the block takes it; push is left
    // high so back-to-back requests need no second assignment in one step
    task automatic send_request(input t_in_kind         kind,
                                input logic [CTX_W-1:0] ctx,
                                input logic [63:0]      base,
                                input logic [63:0]      va,
                                input logic [63:0]      word);
        push         <= 1'b1;
        i_kind       <= kind;
        i_context_id <= ctx;
        i_dir_base   <= base;
        i_virt_addr  <= va;
        i_read_data  <= word;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 12));
    endtask

    // sender holds off until every outstanding result has been popped
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // a well-formed walk with random content: optional base write, translate request,
    // optional base rewrite, then the directory word and the page-table entry
    task automatic random_walk();
        logic [CTX_W-1:0] ctx;
        ctx = CTX_W'($urandom_range(0, NUM_CONTEXTS - 1));
        if ($urandom_range(0, 2) == 0) begin
            // now and then a zero base, which disables the context
            send_request(KIND_SET_BASE, ctx,
                         ($urandom_range(0, 9) == 0) ? 64'h0 : rand64(),
                         rand64(), rand64());
            maybe_idle();
        end
        send_request(KIND_XLATE, ctx, rand64(), rand64(), rand64());
        maybe_idle();
        if ($urandom_range(0, 7) == 0) begin
            // base rewritten while the walk is in flight
            send_request(KIND_SET_BASE, CTX_W'($urandom()), rand64(), rand64(), rand64());
            maybe_idle();
        end
        send_request(KIND_RD_DATA, CTX_W'($urandom()), rand64(), rand64(), rand64());
        maybe_idle();
        send_request(KIND_RD_DATA, CTX_W'($urandom()), rand64(), rand64(), rand64());
        maybe_idle();
    endtask

    initial begin
        logic [63:0] ones;
        int          target;
        bit          paused;
        ones   = '1;
        paused = 1'b0;

        push         <= 1'b0;
        i_kind       <= KIND_SET_BASE;
        i_context_id <= '0;
        i_dir_base   <= '0;
        i_virt_addr  <= '0;
        i_read_data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // every base is zero after reset: answered at once as unmapped
        send_request(KIND_XLATE, 4'd0, '0, ones, ones);
        // memory return with no read pending, and the unused kind: both ignored
        send_request(KIND_RD_DATA, 4'd3, ones, ones, ones);
        send_request(KIND_UNUSED, 4'd15, ones, ones, ones);
        send_request(KIND_SET_BASE, 4'd15, ones, '0, '0);
        send_request(KIND_SET_BASE, 4'd0, 64'h1000, '0, '0);
        // all-ones base and index: directory address wraps
        send_request(KIND_XLATE, 4'd15, '0, ones, '0);
        // translate while busy is dropped
        send_request(KIND_XLATE, 4'd0, '0, 64'h1234_5678_9ABC_DEF0, '0);
        // base rewritten during the walk; the walk keeps its issued read
        send_request(KIND_SET_BASE, 4'd0, 64'h2000, '0, '0);
        // all-ones directory word: low byte cleared, page-table address wraps
        send_request(KIND_RD_DATA, 4'd0, '0, '0, ones);
        send_request(KIND_SET_BASE, 4'd15, 64'h8000_0000_0000_0000, '0, '0);
        send_request(KIND_RD_DATA, 4'd0, '0, '0, ones);
        // all-zero address and table words: mapped to physical zero
        send_request(KIND_XLATE, 4'd0, ones, '0, ones);
        send_request(KIND_RD_DATA, 4'd0, ones, ones, '0);
        send_request(KIND_RD_DATA, 4'd0, ones, ones, '0);
        // writing zero disables the context again
        send_request(KIND_SET_BASE, 4'd15, '0, ones, ones);
        send_request(KIND_XLATE, 4'd15, ones, rand64(), ones);
        send_request(KIND_XLATE, 4'd0, rand64(), rand64(), rand64());
        send_request(KIND_RD_DATA, 4'd0, rand64(), rand64(), rand64());
        send_request(KIND_RD_DATA, 4'd0, rand64(), rand64(), rand64());
        send_request(KIND_RD_DATA, 4'd7, rand64(), rand64(), ones);
        drain_results();

        // --- random part ---
        target = effective + RANDOM_TARGET;
        while (effective < target) begin
            if ($urandom_range(0, 9) < 7) begin
                random_walk();
            end else begin
                // noise: any kind, any fields, broken and stray walk steps
                send_request(t_in_kind'($urandom_range(0, 3)), CTX_W'($urandom()),
                             rand64(), rand64(), rand64());
                maybe_idle();
            end
            if (!paused && effective >= target - RANDOM_TARGET / 2) begin
                paused = 1'b1;
                drain_results();
            end
            if (effective >= target - QUIET_TAIL)
                quiet = 1'b1;
        end

        // --- wind-down ---
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a stray late result still gets caught
        repeat (20) @(posedge i_clk);

        $display("Covered %0d working requests: %0d completed walks, %0d unmapped answers.",
                 effective, walks_done, unmapped);
        $display("Compared %0d results, %0d failures.", compared, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
